FILE: rtl/ndc_pkg.sv
// Shared types and constants of the dinucleotide counter.
// No dependencies; every other file of the block imports this package.
package ndc_pkg;

   localparam int HIST_BINS   = 256;
   localparam int NUM_BASES   = 4;
   localparam int NUM_PAIRS   = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int RSP_BITS    = 32;

   localparam logic OP_COUNT = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_T = 8'h54;

   localparam logic [1:0] BASE_A = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_G = 2'd2;
   localparam logic [1:0] BASE_T = 2'd3;

   localparam logic [8:0] PAIR_INDEX = 9'd260;
   localparam logic [8:0] LAST_INDEX = 9'd275;

   // Counter set that a read request selects
   localparam logic [1:0] SRC_HIST = 2'd0;
   localparam logic [1:0] SRC_BASE = 2'd1;
   localparam logic [1:0] SRC_PAIR = 2'd2;
   localparam logic [1:0] SRC_NONE = 2'd3;

   typedef struct packed {
      logic       op;
      logic [7:0] hist_addr;
      logic       base_en;
      logic [1:0] base_sel;
      logic       pair_en;
      logic [3:0] pair_sel;
      logic [1:0] src;
   } cmd_type;

endpackage

FILE: rtl/ndc_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on ndc_pkg for the response width.
interface ndc_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] ch;
   logic       end_of_sequence;
   logic [8:0] read_index;

   modport source (output valid, output op, output ch, output end_of_sequence,
                   output read_index, input ready);
   modport sink (input valid, input op, input ch, input end_of_sequence,
                 input read_index, output ready);
endinterface

interface ndc_rsp_if;
   import ndc_pkg::*;
   logic                valid;
   logic                ready;
   logic [RSP_BITS-1:0] count_value;

   modport source (output valid, output count_value, input ready);
   modport sink (input valid, input count_value, output ready);
endinterface

FILE: rtl/ndc_queue.sv
// Small command queue between the classifier and the counter engine.
// Depends on ndc_pkg for the command type and depth.
module ndc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ndc_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output ndc_pkg::cmd_type pop_data
);
   import ndc_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   fill_ff, fill_in;

   assign full      = (fill_ff == CNT_BITS'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/ndc_front.sv
// Request classifier: decodes bases, tracks the previous base within a
// sequence and builds one counter command per transfer. Depends on ndc_pkg.
module ndc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_op,
   input  logic [7:0]       req_ch,
   input  logic             req_end_of_sequence,
   input  logic [8:0]       req_read_index,
   input  logic             queue_full,
   output logic             push,
   output ndc_pkg::cmd_type cmd
);
   import ndc_pkg::*;

   logic       prev_is_base_ff, prev_is_base_in;
   logic [1:0] prev_base_ff, prev_base_in;
   logic       base_hit;
   logic [1:0] base_code;
   logic [8:0] pair_offset;

   assign req_ready   = !queue_full;
   assign push        = req_valid && req_ready;
   assign pair_offset = req_read_index - PAIR_INDEX;

   always_comb begin
      base_hit  = 1'b1;
      base_code = BASE_A;
      case (req_ch)
         CHAR_A:  base_code = BASE_A;
         CHAR_C:  base_code = BASE_C;
         CHAR_G:  base_code = BASE_G;
         CHAR_T:  base_code = BASE_T;
         default: base_hit  = 1'b0;
      endcase
   end

   always_comb begin
      cmd.op        = req_op;
      cmd.hist_addr = req_ch;
      cmd.base_en   = 1'b0;
      cmd.base_sel  = base_code;
      cmd.pair_en   = 1'b0;
      cmd.pair_sel  = {prev_base_ff, base_code};
      cmd.src       = SRC_NONE;
      if (req_op == OP_COUNT) begin
         cmd.base_en = base_hit;
         cmd.pair_en = base_hit && prev_is_base_ff;
      end else begin
         cmd.hist_addr = req_read_index[7:0];
         cmd.base_sel  = req_read_index[1:0];
         cmd.pair_sel  = pair_offset[3:0];
         if (!req_read_index[8]) begin
            cmd.src = SRC_HIST;
         end else if (req_read_index < PAIR_INDEX) begin
            cmd.src = SRC_BASE;
         end else if (req_read_index <= LAST_INDEX) begin
            cmd.src = SRC_PAIR;
         end
      end
   end

   // A read leaves the pair tracking untouched
   always_comb begin
      prev_is_base_in = prev_is_base_ff;
      prev_base_in    = prev_base_ff;
      if (push && req_op == OP_COUNT) begin
         prev_is_base_in = base_hit && !req_end_of_sequence;
         if (base_hit) begin
            prev_base_in = base_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_is_base_ff <= 1'b0;
         prev_base_ff    <= BASE_A;
      end else begin
         prev_is_base_ff <= prev_is_base_in;
         prev_base_ff    <= prev_base_in;
      end
   end

endmodule

FILE: rtl/ndc_back.sv
// Counter engine: histogram memory with per-bin valid bits, base and pair
// counters, saturating read-modify-write and the response register.
// Depends on ndc_pkg.
module ndc_back #(
   parameter int COUNT_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_avail,
   input  ndc_pkg::cmd_type             cmd,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ndc_pkg::RSP_BITS-1:0] rsp_count_value
);
   import ndc_pkg::*;

   localparam logic ST_FETCH = 1'b0;
   localparam logic ST_EXEC  = 1'b1;

   logic                  state_ff, state_in;
   cmd_type               cmd_ff;
   logic [COUNT_BITS-1:0] hist_mem [HIST_BINS];
   logic [HIST_BINS-1:0]  hist_vld_ff;
   logic [COUNT_BITS-1:0] hist_rd_ff;
   logic                  hist_hit_ff;
   logic [COUNT_BITS-1:0] base_cnt_ff [NUM_BASES];
   logic [COUNT_BITS-1:0] pair_cnt_ff [NUM_PAIRS];
   logic                  rsp_valid_ff;
   logic [RSP_BITS-1:0]   rsp_data_ff;

   logic [COUNT_BITS-1:0] hist_cur;
   logic [COUNT_BITS-1:0] base_cur;
   logic [COUNT_BITS-1:0] pair_cur;
   logic [COUNT_BITS-1:0] sel_val;
   logic [RSP_BITS-1:0]   rsp_word;
   logic                  slot_free;
   logic                  done;
   logic                  do_count;
   logic                  do_read;

   function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
      logic [COUNT_BITS-1:0] r;
      r = (&v) ? v : v + COUNT_BITS'(1);
      return r;
   endfunction

   assign pop       = (state_ff == ST_FETCH) && cmd_avail;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign done      = (state_ff == ST_EXEC) && (cmd_ff.op == OP_COUNT || slot_free);
   assign do_count  = done && cmd_ff.op == OP_COUNT;
   assign do_read   = done && cmd_ff.op == OP_READ;

   // A bin never written reads as zero
   assign hist_cur = hist_hit_ff ? hist_rd_ff : '0;
   assign base_cur = base_cnt_ff[cmd_ff.base_sel];
   assign pair_cur = pair_cnt_ff[cmd_ff.pair_sel];

   always_comb begin
      case (cmd_ff.src)
         SRC_HIST: sel_val = hist_cur;
         SRC_BASE: sel_val = base_cur;
         SRC_PAIR: sel_val = pair_cur;
         default:  sel_val = '0;
      endcase
   end

   generate
      if (COUNT_BITS > RSP_BITS) begin : g_clamp
         assign rsp_word = (|sel_val[COUNT_BITS-1:RSP_BITS]) ? '1 : sel_val[RSP_BITS-1:0];
      end else begin : g_extend
         assign rsp_word = RSP_BITS'(sel_val);
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_FETCH: if (pop) state_in = ST_EXEC;
         ST_EXEC:  if (done) state_in = ST_FETCH;
         default:  state_in = ST_FETCH;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FETCH;
         rsp_valid_ff <= 1'b0;
         hist_vld_ff  <= '0;
         for (int i = 0; i < NUM_BASES; i++) begin
            base_cnt_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_PAIRS; i++) begin
            pair_cnt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (do_read) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (do_count) begin
            hist_vld_ff[cmd_ff.hist_addr] <= 1'b1;
            if (cmd_ff.base_en) begin
               base_cnt_ff[cmd_ff.base_sel] <= bump(base_cur);
            end
            if (cmd_ff.pair_en) begin
               pair_cnt_ff[cmd_ff.pair_sel] <= bump(pair_cur);
            end
         end
      end
   end

   // Hold the command and the fetched bin until the engine finishes it
   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff      <= cmd;
         hist_rd_ff  <= hist_mem[cmd.hist_addr];
         hist_hit_ff <= hist_vld_ff[cmd.hist_addr];
      end
      if (do_count) begin
         hist_mem[cmd_ff.hist_addr] <= bump(hist_cur);
      end
      if (do_read) begin
         rsp_data_ff <= rsp_word;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_count_value = rsp_data_ff;

endmodule

FILE: rtl/nucleotide_digram_counter.sv
// Top level of the dinucleotide counter: classifier, command queue and
// counter engine. Depends on ndc_pkg, ndc_if, ndc_front, ndc_queue, ndc_back.
//
// Usage:
//   req_chan carries one request per transfer. op = count adds the byte ch
//   to its histogram bin, to its base counter when it is A, C, G or T, and
//   to the pair counter of the previous and this base when both are bases
//   of the same sequence; end_of_sequence closes the sequence. op = read
//   returns one counter by read_index on rsp_chan (0-255 bins, 256-259
//   bases, 260-275 pairs, higher indexes read zero). Counters saturate.
//   The engine finishes each request before it takes the next, as the
//   histogram memory needs a read-modify-write (one registered read, then
//   one write). A read's response passes the queue entry, the command
//   register and the response register before it turns valid on rsp_chan.
//   A two-entry queue lets requests keep arriving while the engine
//   works; a stalled response holds rsp_chan and, once the queue fills,
//   req_chan.ready drops. Reset clears all counters at once, the histogram
//   bins through one valid bit per bin; no clearing pass is needed.
module nucleotide_digram_counter #(
   parameter int COUNT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   ndc_req_if.sink     req_chan,
   ndc_rsp_if.source   rsp_chan
);
   import ndc_pkg::*;

   cmd_type front_cmd;
   cmd_type queue_cmd;
   logic    push;
   logic    pop;
   logic    queue_full;
   logic    queue_avail;

   ndc_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_chan.valid),
      .req_ready           (req_chan.ready),
      .req_op              (req_chan.op),
      .req_ch              (req_chan.ch),
      .req_end_of_sequence (req_chan.end_of_sequence),
      .req_read_index      (req_chan.read_index),
      .queue_full          (queue_full),
      .push                (push),
      .cmd                 (front_cmd)
   );

   ndc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_cmd),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_avail),
      .pop_data  (queue_cmd)
   );

   ndc_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_avail       (queue_avail),
      .cmd             (queue_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_count_value (rsp_chan.count_value)
   );

endmodule

FILE: bench/nucleotide_digram_counter_tb.sv
// Self-checking bench for nucleotide_digram_counter: random request streams
// and response stalls, with a class that tracks the counters and checks every read.
// Depends on ndc_pkg, ndc_if and the nucleotide_digram_counter RTL.
module nucleotide_digram_counter_tb;
   import ndc_pkg::*;

   localparam int ITEM_TARGET = 1950;
   localparam int MAX_WAIT    = 12;
   localparam int LONG_HOLD   = 300;
   localparam int DRAIN       = 20;

   class digram_scoreboard;
      logic [31:0] char_bins[HIST_BINS];
      logic [31:0] base_tally[NUM_BASES];
      logic [31:0] pair_tally[NUM_PAIRS];
      logic [1:0]  last_base;
      bit          last_was_base;
      logic [31:0] pending_values[$];
      int          failures;

      function new();
         foreach (char_bins[i]) char_bins[i] = '0;
         foreach (base_tally[i]) base_tally[i] = '0;
         foreach (pair_tally[i]) pair_tally[i] = '0;
         last_base = BASE_A;
         last_was_base = 0;
         failures = 0;
      endfunction

      function logic [31:0] bump(logic [31:0] c);
         return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
      endfunction

      // Apply one accepted request; a read queues the value it must return.
      function void note_request(logic op, logic [7:0] ch, logic eos, logic [8:0] idx);
         logic [1:0]  code;
         bit          is_base;
         logic [8:0]  offset;
         logic [31:0] value;
         if (op == OP_COUNT) begin
            char_bins[ch] = bump(char_bins[ch]);
            is_base = 1;
            code = BASE_A;
            case (ch)
               CHAR_A: code = BASE_A;
               CHAR_C: code = BASE_C;
               CHAR_G: code = BASE_G;
               CHAR_T: code = BASE_T;
               default: is_base = 0;
            endcase
            if (is_base) begin
               base_tally[code] = bump(base_tally[code]);
               if (last_was_base)
                  pair_tally[{last_base, code}] = bump(pair_tally[{last_base, code}]);
               last_base = code;
            end
            // a pair never spans a non-base byte or a sequence boundary
            last_was_base = is_base && !eos;
         end else begin
            value = '0;
            offset = idx - PAIR_INDEX;
            if (idx < HIST_BINS)
               value = char_bins[idx[7:0]];
            else if (idx < PAIR_INDEX)
               value = base_tally[idx[1:0]];
            else if (idx <= LAST_INDEX)
               value = pair_tally[offset[3:0]];
            pending_values.push_back(value);
         end
      endfunction

      function void check_response(logic [31:0] value);
         logic [31:0] want;
         if (pending_values.size() == 0) begin
            $error("unexpected response: count_value actual %0d", value);
            failures++;
         end else begin
            want = pending_values.pop_front();
            if (value !== want) begin
               $error("count_value: expected %0d, actual %0d", want, value);
               failures++;
            end
         end
      endfunction

      function int pending();
         return pending_values.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   ndc_req_if req_chan();
   ndc_rsp_if rsp_chan();

   nucleotide_digram_counter uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   digram_scoreboard board = new();

   int items_sent = 0;
   bit tx_calm = 0;
   bit rx_calm = 0;
   bit rx_long_hold = 0;

   always #5 clock = ~clock;

   initial begin
      clock = 0;
      reset = 1;
      req_chan.valid = 0;
      req_chan.op = OP_COUNT;
      req_chan.ch = '0;
      req_chan.end_of_sequence = 0;
      req_chan.read_index = '0;
      rsp_chan.ready = 0;
   end

   initial begin
      #3_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int draw_wait(bit calm);
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic logic [8:0] pick_index();
      logic [7:0] letters[4];
      letters = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 9'($urandom_range(256, 275));
         4, 5:       return {1'b0, letters[$urandom_range(0, 3)]};
         6, 7:       return 9'($urandom_range(0, 255));
         default:    return 9'($urandom_range(276, 511));
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_request(logic op, logic [7:0] ch, logic eos, logic [8:0] idx);
      int gap;
      gap = draw_wait(tx_calm);
      if (gap > 0) begin
         req_chan.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1;
      req_chan.op <= op;
      req_chan.ch <= ch;
      req_chan.end_of_sequence <= eos;
      req_chan.read_index <= idx;
      do @(posedge clock); while (!req_chan.ready);
      board.note_request(op, ch, eos, idx);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_count(logic [7:0] ch, logic eos);
      send_request(OP_COUNT, ch, eos, 9'($urandom_range(0, 511)));
   endtask

   task automatic send_read(logic [8:0] idx);
      send_request(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), idx);
   endtask

   // Response side: random stalls, plus one long hold when asked.
   initial begin
      int gap;
      wait (reset == 0);
      @(negedge clock);
      forever begin
         if (rx_long_hold) begin
            rsp_chan.ready <= 0;
            repeat (LONG_HOLD) @(negedge clock);
            rx_long_hold = 0;
         end
         gap = draw_wait(rx_calm);
         if (gap > 0) begin
            rsp_chan.ready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1;
         do @(posedge clock); while (!rsp_chan.valid);
         board.check_response(rsp_chan.count_value);
         @(negedge clock);
      end
   end

   initial begin
      int          len;
      logic [7:0]  letters[4];
      logic [7:0]  lower[4];
      logic [7:0]  ch;
      bit          hold_done;
      bit          pause_done;
      letters = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T};
      lower = '{8'h61, 8'h63, 8'h67, 8'h74};
      hold_done = 0;
      pause_done = 0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: empty counters, all pairs of one sequence, breaks and limits
      send_read(9'd256);
      send_count(CHAR_A, 0);
      send_count(CHAR_C, 0);
      send_count(CHAR_G, 0);
      send_count(CHAR_T, 1);
      send_count(CHAR_T, 0);
      send_count(8'h61, 0);
      send_count(CHAR_G, 0);
      send_count(CHAR_G, 0);
      send_count(8'hFF, 0);
      send_count(8'h00, 1);
      send_count(CHAR_A, 1);
      send_read(9'd270);
      send_read(9'd511);
      send_read(9'd276);
      send_read(9'd255);
      send_read(9'd0);
      send_read({1'b0, CHAR_A});
      send_read(LAST_INDEX);
      send_read(9'd259);
      // a read between two bases must not break the pair
      send_count(CHAR_C, 0);
      send_read(9'd257);
      send_count(CHAR_G, 1);
      send_read(9'd266);
      send_read(PAIR_INDEX);

      while (items_sent < ITEM_TARGET) begin
         tx_calm = ($urandom_range(0, 5) == 0);
         rx_calm = ($urandom_range(0, 5) == 0);
         if (!hold_done && items_sent > 600) begin
            // stall the response side while reads keep coming to fill the queue
            hold_done = 1;
            rx_long_hold = 1;
            tx_calm = 1;
            repeat (40) send_read(pick_index());
         end
         if (!pause_done && items_sent > 1200) begin
            pause_done = 1;
            req_chan.valid <= 0;
            do @(negedge clock); while (board.pending() != 0);
         end
         if ($urandom_range(0, 9) < 7) begin
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 3) == 0)
                  send_read(pick_index());
               case ($urandom_range(0, 19))
                  0:       ch = 8'($urandom_range(0, 255));
                  1:       ch = lower[$urandom_range(0, 3)];
                  default: ch = letters[$urandom_range(0, 3)];
               endcase
               send_count(ch, i == len - 1);
            end
         end else begin
            len = $urandom_range(1, 10);
            repeat (len) begin
               if ($urandom_range(0, 1) == 0)
                  send_read(pick_index());
               else
                  send_count(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
         end
      end

      req_chan.valid <= 0;
      while (board.pending() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      if (board.failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
